// ----- design/pce_pkg.sv -----
// Shared types and constants of the polynomial coefficient store and evaluator.
// Request and response payloads, action codes and 32-bit saturation limits.
// Depends on nothing; the evaluator module and the testbench import it.
package pce_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_EVAL  = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [3:0]         exponent;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_low;
        logic signed [31:0] x_high;
    } t_req;

    typedef struct packed {
        logic signed [31:0] poly_value;
        logic signed [31:0] area;
        logic [3:0]         poly_degree;
        logic               all_zero;
        logic               saturated;
    } t_rsp;

    localparam logic signed [63:0] SAT_MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN64 = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [32:0] SAT_MAX33 = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] SAT_MIN33 = 33'sh1_8000_0000;

endpackage

// ----- design/pce_stream_if.sv -----
// Valid/ready request channel carrying one payload of type T per request.
// Used for the request and response sides of the evaluator; no dependencies.
// The source drives valid and data, the sink drives ready.
interface pce_stream_if #(
    parameter type T = logic [0:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/polynomial_coef_store_evaluator.sv -----
// Evaluation runs one Horner step per trip around the multiply and accumulate registers
// of the recurrence; the coefficient memory port and divider run ahead of it.
// One request is processed at a time; a new one is taken while a response waits.
// Reset empties the store through per-entry valid bits; there is no clearing pass.
module polynomial_coef_store_evaluator #(
    parameter int NUM_COEFS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pce_stream_if.sink     i_req,
    pce_stream_if.source   o_rsp
);
    import pce_pkg::*;

    localparam int AW  = $clog2(NUM_COEFS);
    localparam int CW  = $clog2(NUM_COEFS + 1);
    localparam int QKW = 32 + CW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_EVAL,
        S_AREA,
        S_DONE
    } t_state;

    function automatic logic [32:0] sat33(input logic signed [32:0] s);
        logic [32:0] res;
        if (s > SAT_MAX33) begin
            res = {1'b1, SAT_MAX33[31:0]};
        end else if (s < SAT_MIN33) begin
            res = {1'b1, SAT_MIN33[31:0]};
        end else begin
            res = {1'b0, s[31:0]};
        end
        return res;
    endfunction

    function automatic logic [33:0] horner_step(input logic signed [63:0] prod,
                                                input logic signed [31:0] coef);
        logic signed [63:0] sh;
        logic signed [31:0] t;
        logic               f;
        logic [32:0]        s;
        sh = prod >>> FRAC_BITS;
        f  = 1'b0;
        if (sh > SAT_MAX64) begin
            t = SAT_MAX64[31:0];
            f = 1'b1;
        end else if (sh < SAT_MIN64) begin
            t = SAT_MIN64[31:0];
            f = 1'b1;
        end else begin
            t = sh[31:0];
        end
        s = sat33({t[31], t} + {coef[31], coef});
        return {f, s};
    endfunction

    function automatic logic [3:0] top_degree(input logic [NUM_COEFS-1:0] nz);
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < NUM_COEFS; i++) begin
            if (nz[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

    // Coefficient memory and its control.
    logic [31:0]          mem [NUM_COEFS];
    logic [31:0]          r_rd_data;
    logic                 r_rd_ok;
    logic [NUM_COEFS-1:0] r_vld;
    logic [NUM_COEFS-1:0] r_nz;

    t_state               r_state;
    logic                 r_ph;
    logic                 r_issue_done;
    logic [CW-1:0]        r_cnt;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_addr;
    logic signed [31:0]   r_coef;

    logic                 r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    logic                 r_p1_last, r_p2_last, r_p3_last, r_p4_last;
    logic [AW-1:0]        r_p1_idx, r_p2_idx, r_p3_idx;
    logic [63:0]          r_p2_prod;
    logic [31:0]          r_p2_abs, r_p3_abs;
    logic                 r_p2_neg, r_p3_neg;
    logic signed [31:0]   r_p2_c, r_p3_c, r_p4_c;
    logic [31:0]          r_p3_q0, r_p3_qk;
    logic signed [31:0]   r_p4_a;

    logic signed [31:0]   r_xhi, r_xlo;
    logic signed [31:0]   r_acc_v, r_acc_h, r_acc_l;
    logic signed [63:0]   r_prod_v, r_prod_h, r_prod_l;
    logic signed [31:0]   r_res_value, r_res_area;
    logic                 r_sat;

    t_rsp                 r_out;
    logic                 r_out_vld;

    logic [31:0]          w_recip [NUM_COEFS];
    t_req                 w_req;
    logic                 w_take;
    logic                 w_in_range;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_issue;
    logic                 w_issue_last;
    logic [31:0]          w_rd_val;
    logic [32:0]          w_add;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [31:0]          w_wdata;
    logic [31:0]          w_s1_abs;
    logic                 w_s1_neg;
    logic [CW-1:0]        w_k2, w_k3;
    logic [31:0]          w_q0;
    logic [31:0]          w_rem;
    logic [31:0]          w_q;
    logic signed [31:0]   w_a;
    logic [33:0]          w_hv, w_hh, w_hl;
    logic [32:0]          w_area;
    logic                 w_out_free;

    for (genvar g = 0; g < NUM_COEFS; g++) begin : g_recip
        localparam logic [31:0] RECIP_VAL = 32'(64'hFFFF_FFFF / (g + 1));
        assign w_recip[g] = RECIP_VAL;
    end

    assign w_req        = i_req.data;
    assign i_req.ready  = (r_state == S_IDLE);
    assign w_take       = i_req.valid && i_req.ready;
    assign w_in_range   = ({28'd0, w_req.exponent} < 32'(NUM_COEFS));
    assign w_rd_addr    = (r_state == S_EVAL) ? r_idx : AW'(w_req.exponent);
    assign w_issue      = (r_state == S_EVAL) && !r_ph && !r_issue_done;
    assign w_issue_last = (r_cnt == CW'(NUM_COEFS));
    assign w_rd_val     = r_rd_ok ? r_rd_data : 32'd0;

    assign w_add   = sat33({w_rd_val[31], w_rd_val} + {r_coef[31], r_coef});
    assign w_we    = (w_take && (w_req.action == ACT_WRITE) && w_in_range)
                     || (r_state == S_ADD);
    assign w_waddr = (r_state == S_ADD) ? r_addr : AW'(w_req.exponent);
    assign w_wdata = (r_state == S_ADD) ? w_add[31:0] : w_req.coef_value;

    // Antiderivative coefficient c/(i+1): reciprocal multiply and one correction.
    assign w_s1_neg = w_rd_val[31];
    assign w_s1_abs = w_s1_neg ? (~w_rd_val + 32'd1) : w_rd_val;
    assign w_k2     = CW'(r_p2_idx) + CW'(1);
    assign w_k3     = CW'(r_p3_idx) + CW'(1);
    assign w_q0     = r_p2_prod[63:32];
    assign w_rem    = r_p3_abs - r_p3_qk;
    assign w_q      = r_p3_q0 + {31'd0, (w_rem >= 32'(w_k3))};
    assign w_a      = r_p3_last ? 32'sd0 : (r_p3_neg ? (~w_q + 32'd1) : w_q);

    assign w_hv   = horner_step(r_prod_v, r_p4_c);
    assign w_hh   = horner_step(r_prod_h, r_p4_a);
    assign w_hl   = horner_step(r_prod_l, r_p4_a);
    assign w_area = sat33({r_acc_h[31], r_acc_h} - {r_acc_l[31], r_acc_l});

    assign w_out_free  = !r_out_vld || o_rsp.ready;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_vld[w_rd_addr];

        r_p1_idx  <= r_idx;
        r_p2_prod <= 64'(w_s1_abs) * 64'(w_recip[r_p1_idx]);
        r_p2_abs  <= w_s1_abs;
        r_p2_neg  <= w_s1_neg;
        r_p2_c    <= w_rd_val;
        r_p2_idx  <= r_p1_idx;
        r_p3_qk   <= 32'(QKW'(w_q0) * QKW'(w_k2));
        r_p3_q0   <= w_q0;
        r_p3_abs  <= r_p2_abs;
        r_p3_neg  <= r_p2_neg;
        r_p3_c    <= r_p2_c;
        r_p3_idx  <= r_p2_idx;
        r_p4_a    <= w_a;
        r_p4_c    <= r_p3_c;

        r_prod_v <= 64'(r_acc_v) * 64'(r_xhi);
        r_prod_h <= 64'(r_acc_h) * 64'(r_xhi);
        r_prod_l <= 64'(r_acc_l) * 64'(r_xlo);

        if (w_take) begin
            r_coef      <= w_req.coef_value;
            r_addr      <= AW'(w_req.exponent);
            r_xhi       <= w_req.x_high;
            r_xlo       <= w_req.x_low;
            r_acc_v     <= '0;
            r_acc_h     <= '0;
            r_acc_l     <= '0;
            r_res_value <= '0;
            r_res_area  <= '0;
            r_sat       <= 1'b0;
        end else if (r_state == S_ADD) begin
            r_sat <= w_add[32];
        end else if (r_state == S_EVAL && r_p4_vld) begin
            if (!r_p4_last) begin
                r_acc_v <= w_hv[31:0];
            end
            r_acc_h <= w_hh[31:0];
            r_acc_l <= w_hl[31:0];
            r_sat   <= r_sat || w_hh[33] || w_hh[32] || w_hl[33] || w_hl[32]
                       || (!r_p4_last && (w_hv[33] || w_hv[32]));
        end else if (r_state == S_AREA) begin
            r_res_value <= r_acc_v;
            r_res_area  <= w_area[31:0];
            r_sat       <= r_sat || w_area[32];
        end

        if (r_state == S_DONE && w_out_free) begin
            r_out.poly_value  <= r_res_value;
            r_out.area        <= r_res_area;
            r_out.poly_degree <= top_degree(r_nz);
            r_out.all_zero    <= (r_nz == '0);
            r_out.saturated   <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vld        <= '0;
            r_nz         <= '0;
            r_ph         <= 1'b0;
            r_issue_done <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_p3_vld     <= 1'b0;
            r_p4_vld     <= 1'b0;
            r_p1_last    <= 1'b0;
            r_p2_last    <= 1'b0;
            r_p3_last    <= 1'b0;
            r_p4_last    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_p1_vld  <= w_issue;
            r_p1_last <= w_issue && w_issue_last;
            r_p2_vld  <= r_p1_vld;
            r_p2_last <= r_p1_last;
            r_p3_vld  <= r_p2_vld;
            r_p3_last <= r_p2_last;
            r_p4_vld  <= r_p3_vld;
            r_p4_last <= r_p3_last;

            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
                r_nz[w_waddr]  <= (w_wdata != 32'd0);
            end

            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        unique case (w_req.action)
                            ACT_WRITE: r_state <= S_DONE;
                            ACT_ADD:   r_state <= w_in_range ? S_ADD : S_DONE;
                            ACT_CLEAR: begin
                                r_vld   <= '0;
                                r_nz    <= '0;
                                r_state <= S_DONE;
                            end
                            ACT_EVAL: begin
                                r_ph         <= 1'b0;
                                r_issue_done <= 1'b0;
                                r_cnt        <= '0;
                                r_idx        <= AW'(NUM_COEFS - 1);
                                r_state      <= S_EVAL;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_ADD: begin
                    r_state <= S_DONE;
                end
                S_EVAL: begin
                    r_ph <= !r_ph;
                    if (w_issue) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_idx <= r_idx - AW'(1);
                        if (w_issue_last) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    if (r_p4_vld && r_p4_last) begin
                        r_state <= S_AREA;
                    end
                end
                S_AREA: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pipe_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p4_vld |-> (r_state == S_EVAL))
        else $error("Coefficient pipeline active outside evaluation.");

    a_step_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p4_vld |=> !r_p4_vld)
        else $error("Horner steps issued closer than the accumulate loop allows.");

    a_nz_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nz & ~r_vld) == '0)
        else $error("Nonzero mark on an entry that was never written.");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_req.action == ACT_CLEAR)) |=> (r_nz == '0) && (r_vld == '0))
        else $error("Clear request left coefficients in the store.");

    a_done_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_out_vld) |=> (r_state == S_IDLE) && r_out_vld)
        else $error("Finished response not moved to the output register.");

endmodule

// ----- tb/tb_polynomial_coef_store_evaluator.sv -----
// Self-checking testbench for polynomial_coef_store_evaluator: a directed table, then random
// requests, each checked against its table entry or a Horner model of the store and integral.
// Depends on design/pce_pkg.sv, design/pce_stream_if.sv and the top level module.
module tb_polynomial_coef_store_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import pce_pkg::*;

    localparam int NC          = 16;
    localparam int FB          = 16;
    localparam int NUM_RANDOM  = 1300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;

    localparam t_rsp NO_RSP = '0;

    typedef longint t_terms [NC+1];

    typedef struct {
        t_req req;
        bit   known;
        t_rsp want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    pce_stream_if #(.T(t_req)) req_if ();
    pce_stream_if #(.T(t_rsp)) rsp_if ();

    polynomial_coef_store_evaluator #(
        .NUM_COEFS(NC),
        .FRAC_BITS(FB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    longint coef_model [NC];
    t_rsp   awaited_rsp [$];
    t_row   stim_table [$];
    int     fails;
    int     quiet_cycles;
    bit     calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp32(longint v, inout bit hit);
        if (v > SAT_MAX64) begin
            hit = 1'b1;
            return SAT_MAX64;
        end
        if (v < SAT_MIN64) begin
            hit = 1'b1;
            return SAT_MIN64;
        end
        return v;
    endfunction

    function automatic longint horner(t_terms c, int n, longint x, inout bit hit);
        longint acc = 0;
        for (int i = n - 1; i >= 0; i--) begin
            acc = clamp32((acc * x) >>> FB, hit);
            acc = clamp32(acc + c[i], hit);
        end
        return acc;
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_terms plain;
        t_terms anti;
        bit     hit;
        bit     zero;
        int     deg;
        longint value;
        longint area;
        longint f_hi;
        longint f_lo;
        t_rsp   o;
        hit   = 1'b0;
        value = 0;
        area  = 0;
        case (r.action)
            ACT_WRITE: begin
                if (r.exponent < NC) coef_model[r.exponent] = longint'(r.coef_value);
            end
            ACT_ADD: begin
                if (r.exponent < NC)
                    coef_model[r.exponent] =
                        clamp32(coef_model[r.exponent] + longint'(r.coef_value), hit);
            end
            ACT_CLEAR: begin
                foreach (coef_model[i]) coef_model[i] = 0;
            end
            default: begin
                anti[0]   = 0;
                plain[NC] = 0;
                for (int i = 0; i < NC; i++) begin
                    plain[i]    = coef_model[i];
                    anti[i + 1] = coef_model[i] / (i + 1);
                end
                value = horner(plain, NC, longint'(r.x_high), hit);
                f_hi  = horner(anti, NC + 1, longint'(r.x_high), hit);
                f_lo  = horner(anti, NC + 1, longint'(r.x_low), hit);
                area  = clamp32(f_hi - f_lo, hit);
            end
        endcase
        zero = 1'b1;
        deg  = 0;
        for (int i = NC - 1; i >= 0; i--) begin
            if (zero && coef_model[i] != 0) begin
                deg  = i;
                zero = 1'b0;
            end
        end
        o.poly_value  = value[31:0];
        o.area        = area[31:0];
        o.poly_degree = 4'(deg);
        o.all_zero    = zero;
        o.saturated   = hit;
        return o;
    endfunction

    function automatic int idle_len();
        int unsigned pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] rand_fixed(int unsigned span);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2:    return $urandom;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    function automatic void add_row(t_action act, logic [3:0] expo, logic [31:0] coef,
                                    logic [31:0] lo, logic [31:0] hi, bit known, t_rsp want);
        t_row row;
        row.req.action     = act;
        row.req.exponent   = expo;
        row.req.coef_value = coef;
        row.req.x_low      = lo;
        row.req.x_high     = hi;
        row.known          = known;
        row.want           = want;
        stim_table.push_back(row);
    endfunction

    task automatic send_request(t_req r, bit known, t_rsp want);
        int   gap;
        t_rsp predicted;
        gap = idle_len();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = apply_request(r);
        awaited_rsp.push_back(known ? want : predicted);
    endtask

    task automatic check_response(t_rsp got);
        t_rsp want;
        if (awaited_rsp.size() == 0) begin
            fails++;
            $error("response arrived with no request outstanding");
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.poly_value !== want.poly_value) begin
            fails++;
            $error("poly_value: expected %0d, got %0d", want.poly_value, got.poly_value);
        end
        if (got.area !== want.area) begin
            fails++;
            $error("area: expected %0d, got %0d", want.area, got.area);
        end
        if (got.poly_degree !== want.poly_degree) begin
            fails++;
            $error("poly_degree: expected %0d, got %0d", want.poly_degree, got.poly_degree);
        end
        if (got.all_zero !== want.all_zero) begin
            fails++;
            $error("all_zero: expected %0b, got %0b", want.all_zero, got.all_zero);
        end
        if (got.saturated !== want.saturated) begin
            fails++;
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) check_response(rsp_if.data);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[polynomial_coef_store_evaluator] ERROR");
            $finish;
        end
    end

    initial begin
        int stall;
        stall = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                stall--;
            end else begin
                rsp_if.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall = idle_len();
            end
        end
    end

    initial begin
        t_req        r;
        int unsigned pick;
        fails        = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        foreach (coef_model[i]) coef_model[i] = 0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;

        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b1, 1'b0});
        add_row(ACT_WRITE, 4'd15, 32'h7FFF_FFFF, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd15, 1'b0, 1'b0});
        add_row(ACT_ADD,   4'd15, 32'h0000_0001, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd15, 1'b0, 1'b1});
        add_row(ACT_ADD,   4'd15, 32'h8000_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd15, 1'b0, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h8000_0000, 32'h7FFF_FFFF, 0, NO_RSP);
        add_row(ACT_WRITE, 4'd0,  32'h8000_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd15, 1'b0, 1'b0});
        add_row(ACT_ADD,   4'd0,  32'h8000_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd15, 1'b0, 1'b1});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h7FFF_FFFF, 32'h8000_0000, 0, NO_RSP);
        add_row(ACT_CLEAR, 4'd0,  32'h0,         32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b1, 1'b0});
        add_row(ACT_WRITE, 4'd0,  32'h0001_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b0, 1'b0});
        add_row(ACT_WRITE, 4'd1,  32'h0002_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd1, 1'b0, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h0,         32'h0001_0000, 1,
                t_rsp'{32'h0003_0000, 32'h0002_0000, 4'd1, 1'b0, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h0001_0000, 32'h0,         1,
                t_rsp'{32'h0001_0000, 32'hFFFE_0000, 4'd1, 1'b0, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'hFFFF_0000, 32'hFFFF_0000, 0, NO_RSP);
        add_row(ACT_ADD,   4'd1,  32'hFFFE_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b0, 1'b0});
        add_row(ACT_WRITE, 4'd3,  32'h7FFF_FFFF, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd3, 1'b0, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h0,         32'h7FFF_FFFF, 0, NO_RSP);
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'hFFFF_8000, 32'h0001_8000, 0, NO_RSP);
        add_row(ACT_WRITE, 4'd3,  32'h0,         32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b0, 1'b0});
        add_row(ACT_ADD,   4'd7,  32'h0000_0005, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd7, 1'b0, 1'b0});
        add_row(ACT_WRITE, 4'd15, 32'h8000_0000, 32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd15, 1'b0, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h0,         32'h8000_0000, 0, NO_RSP);
        add_row(ACT_CLEAR, 4'd0,  32'h0,         32'h0,         32'h0,         1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b1, 1'b0});
        add_row(ACT_EVAL,  4'd0,  32'h0,         32'h8000_0000, 32'h7FFF_FFFF, 1,
                t_rsp'{32'h0, 32'h0, 4'd0, 1'b1, 1'b0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k]) send_request(stim_table[k].req, stim_table[k].known,
                                             stim_table[k].want);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n % 300) >= 240;
            pick = $urandom_range(0, 99);
            if (pick < 35)      r.action = ACT_WRITE;
            else if (pick < 60) r.action = ACT_ADD;
            else if (pick < 63) r.action = ACT_CLEAR;
            else                r.action = ACT_EVAL;
            r.exponent   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 5))
                                                      : 4'($urandom_range(0, 15));
            r.coef_value = rand_fixed(32'h0004_0000);
            r.x_low      = rand_fixed(32'h0001_8000);
            r.x_high     = rand_fixed(32'h0001_8000);
            send_request(r, 1'b0, NO_RSP);
        end
        req_if.valid <= 1'b0;

        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("[polynomial_coef_store_evaluator] OK");
        end else begin
            $display("[polynomial_coef_store_evaluator] ERROR");
        end
        $finish;
    end

endmodule

// ----- polynomial_coef_store_evaluator.f -----
design/pce_pkg.sv
design/pce_stream_if.sv
design/polynomial_coef_store_evaluator.sv
tb/tb_polynomial_coef_store_evaluator.sv
